FILE: hw/rtl/ddwc_pkg.sv
`default_nettype none

package ddwc_pkg;

    // Register indexes on the configuration port
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx REG_HALF_WIDTH    = 3'd0;
    localparam t_cfg_idx REG_CMD_PER_SPEED = 3'd1;
    localparam t_cfg_idx REG_SPEED_PER_CMD = 3'd2;
    localparam t_cfg_idx REG_INV_TRACK     = 3'd3;
    localparam t_cfg_idx REG_MAX_CMD       = 3'd4;

    localparam int CFG_DATA_W = 24;

    // Reset values
    localparam logic [15:0] HALF_WIDTH_RST    = 16'd19661;
    localparam logic [23:0] CMD_PER_SPEED_RST = 24'd391168;
    localparam logic [23:0] SPEED_PER_CMD_RST = 24'd10980;
    localparam logic [23:0] INV_TRACK_RST     = 24'd109227;
    localparam logic [14:0] MAX_CMD_RST       = 15'd32767;

    // Wheel lanes
    localparam int LANE_R = 0;
    localparam int LANE_L = 1;

    // Quotient bits of the limit scaler (max_cmd is 15 bits)
    localparam int QBITS = 15;

    // Saturation bounds as magnitudes
    localparam logic [33:0] SAT_POS = 34'd32767;
    localparam logic [33:0] SAT_NEG = 34'd32768;

    typedef struct packed {
        logic [15:0] half_width;
        logic [23:0] cmd_per_speed;
        logic [23:0] speed_per_cmd;
        logic [23:0] inv_track;
        logic [14:0] max_cmd;
    } t_cfg;

    // Wheel commands as sign/magnitude plus the limit setup
    typedef struct packed {
        logic [1:0][15:0] mag;
        logic [1:0]       neg;
        logic [15:0]      m;
        logic             limited;
        logic [1:0][29:0] num;
    } t_lim;

    // Final signed commands
    typedef struct packed {
        logic [1:0][15:0] cmd;
        logic             limited;
    } t_cmd;

    function automatic logic [15:0] clamp_mag(input logic neg, input logic [33:0] mag);
        logic [33:0] bound;
        bound = neg ? SAT_NEG : SAT_POS;
        clamp_mag = (mag > bound) ? bound[15:0] : mag[15:0];
    endfunction

    function automatic logic [15:0] apply_sign(input logic neg, input logic [15:0] mag);
        apply_sign = neg ? (~mag + 16'd1) : mag;
    endfunction

    function automatic logic [15:0] sat_signed(input logic neg, input logic [33:0] mag);
        sat_signed = apply_sign(neg, clamp_mag(neg, mag));
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ddwc_wheel.sv
`default_nettype none

// Wheel speeds, motor commands with saturation, limit check (7 stages)
module ddwc_wheel (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [15:0]     i_lin_speed,
    input  wire logic [15:0]     i_turn_rate,
    input  wire ddwc_pkg::t_cfg  i_cfg,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ddwc_pkg::t_lim       o_lim
);

    localparam int NS = 7;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NS-1];

    // s0: turn term w * half_width, Q.26
    logic        [15:0] r0_v;
    logic signed [32:0] r0_turn;
    logic signed [32:0] n0_turn;

    assign n0_turn = $signed(i_turn_rate) * $signed({1'b0, i_cfg.half_width});

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_v    <= i_lin_speed;
            r0_turn <= n0_turn;
        end
    end

    // s1: wheel speeds, 34-bit two's complement
    logic [1:0][33:0] r1_w;
    logic [1:0][33:0] n1_w;
    logic [33:0]      base;
    logic [33:0]      turn_x;

    always_comb begin
        base   = {{2{r0_v[15]}}, r0_v, 16'd0};
        turn_x = {r0_turn[32], r0_turn};
        n1_w[ddwc_pkg::LANE_R] = base + turn_x;
        n1_w[ddwc_pkg::LANE_L] = base - turn_x;
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_w <= n1_w;
        end
    end

    // s2: sign/magnitude; the left command carries the opposite sign
    logic [1:0][32:0] r2_mag;
    logic [1:0]       r2_neg;
    logic [1:0][32:0] n2_mag;
    logic [1:0]       n2_neg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n2_mag[l] = r1_w[l][33] ? (~r1_w[l][32:0] + 33'd1) : r1_w[l][32:0];
        end
        n2_neg[ddwc_pkg::LANE_R] = r1_w[ddwc_pkg::LANE_R][33];
        n2_neg[ddwc_pkg::LANE_L] = ~r1_w[ddwc_pkg::LANE_L][33];
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_mag <= n2_mag;
            r2_neg <= n2_neg;
        end
    end

    // s3: partial products of magnitude * cmd_per_speed
    logic [1:0][40:0] r3_pph;
    logic [1:0][39:0] r3_ppl;
    logic [1:0]       r3_neg;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int l = 0; l < 2; l++) begin
                r3_pph[l] <= r2_mag[l][32:16] * i_cfg.cmd_per_speed;
                r3_ppl[l] <= r2_mag[l][15:0] * i_cfg.cmd_per_speed;
            end
            r3_neg <= r2_neg;
        end
    end

    // s4: sum partials, Q.34 -> integer
    logic [1:0][56:0] n4_full;
    logic [1:0][22:0] r4_p;
    logic [1:0]       r4_neg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n4_full[l] = {r3_pph[l], 16'd0} + {17'd0, r3_ppl[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            for (int l = 0; l < 2; l++) begin
                r4_p[l] <= n4_full[l][56:34];
            end
            r4_neg <= r3_neg;
        end
    end

    // s5: saturate to 16-bit signed range, kept as magnitude
    logic [1:0][15:0] r5_mag;
    logic [1:0]       r5_neg;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            for (int l = 0; l < 2; l++) begin
                r5_mag[l] <= ddwc_pkg::clamp_mag(r4_neg[l], {11'd0, r4_p[l]});
            end
            r5_neg <= r4_neg;
        end
    end

    // s6: larger magnitude, limit check, scaler numerators
    ddwc_pkg::t_lim   r6_lim;
    ddwc_pkg::t_lim   n6_lim;
    logic [1:0][30:0] n6_prod;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n6_prod[l]    = r5_mag[l] * i_cfg.max_cmd;
            n6_lim.num[l] = n6_prod[l][29:0];
        end
        n6_lim.mag     = r5_mag;
        n6_lim.neg     = r5_neg;
        n6_lim.m       = (r5_mag[ddwc_pkg::LANE_R] > r5_mag[ddwc_pkg::LANE_L]) ?
                         r5_mag[ddwc_pkg::LANE_R] : r5_mag[ddwc_pkg::LANE_L];
        n6_lim.limited = n6_lim.m > {1'b0, i_cfg.max_cmd};
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r6_lim <= n6_lim;
        end
    end

    assign o_lim = r6_lim;

endmodule

`default_nettype wire

FILE: hw/rtl/ddwc_div.sv
`default_nettype none

// Ratio-keeping scaler: mag * max_cmd / m, one quotient bit per stage,
// then a select stage that forms the signed commands
module ddwc_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire ddwc_pkg::t_lim  i_lim,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ddwc_pkg::t_cmd       o_cmd
);

    localparam int QB = ddwc_pkg::QBITS;
    localparam int NS = QB + 1;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NS-1];

    ddwc_pkg::t_lim          r_pl  [QB];
    logic [1:0][15:0]        r_rem [QB];
    logic [1:0][QB-1:0]      r_q   [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_step
            ddwc_pkg::t_lim     pl_in;
            logic [1:0][15:0]   rem_in;
            logic [1:0][QB-1:0] q_in;
            logic [1:0][16:0]   trial;
            logic [1:0][16:0]   diff;
            logic [1:0]         ge;
            logic [1:0][15:0]   n_rem;
            logic [1:0][QB-1:0] n_q;

            if (k == 0) begin : g_first
                always_comb begin
                    pl_in = i_lim;
                    for (int l = 0; l < 2; l++) begin
                        rem_in[l] = {1'b0, i_lim.num[l][2*QB-1:QB]};
                    end
                    q_in = '0;
                end
            end else begin : g_next
                always_comb begin
                    pl_in  = r_pl[k-1];
                    rem_in = r_rem[k-1];
                    q_in   = r_q[k-1];
                end
            end

            always_comb begin
                for (int l = 0; l < 2; l++) begin
                    trial[l] = {rem_in[l], pl_in.num[l][QB-1-k]};
                    diff[l]  = trial[l] - {1'b0, pl_in.m};
                    ge[l]    = trial[l] >= {1'b0, pl_in.m};
                    n_rem[l] = ge[l] ? diff[l][15:0] : trial[l][15:0];
                    n_q[l]   = {q_in[l][QB-2:0], ge[l]};
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv[k]) begin
                    r_pl[k]  <= pl_in;
                    r_rem[k] <= n_rem;
                    r_q[k]   <= n_q;
                end
            end
        end
    endgenerate

    // Select scaled or original magnitude, apply sign
    ddwc_pkg::t_cmd r_cmd;
    ddwc_pkg::t_cmd n_cmd;
    ddwc_pkg::t_lim pl_last;

    always_comb begin
        pl_last = r_pl[QB-1];
        for (int l = 0; l < 2; l++) begin
            n_cmd.cmd[l] = ddwc_pkg::apply_sign(pl_last.neg[l],
                pl_last.limited ? {1'b0, r_q[QB-1][l]} : pl_last.mag[l]);
        end
        n_cmd.limited = pl_last.limited;
    end

    always_ff @(posedge i_clk) begin
        if (adv[NS-1]) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd = r_cmd;

endmodule

`default_nettype wire

FILE: hw/rtl/ddwc_odom.sv
`default_nettype none

// Achieved speed and yaw rate from the final commands (5 stages)
module ddwc_odom (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire ddwc_pkg::t_cmd  i_cmd,
    input  wire ddwc_pkg::t_cfg  i_cfg,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ddwc_pkg::t_cmd       o_cmd,
    output logic [15:0]          o_actual_speed,
    output logic [15:0]          o_actual_turn
);

    localparam int NS = 5;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NS-1];

    // Commands ride along to the output
    ddwc_pkg::t_cmd r_c [NS];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_c[0] <= i_cmd;
        end
        for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
                r_c[k] <= r_c[k-1];
            end
        end
    end

    // s0: difference and sum of commands
    logic [16:0] rc_x;
    logic [16:0] lc_x;
    logic [16:0] r0_d;
    logic [16:0] r0_s;

    assign rc_x = {i_cmd.cmd[ddwc_pkg::LANE_R][15], i_cmd.cmd[ddwc_pkg::LANE_R]};
    assign lc_x = {i_cmd.cmd[ddwc_pkg::LANE_L][15], i_cmd.cmd[ddwc_pkg::LANE_L]};

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_d <= rc_x - lc_x;
            r0_s <= rc_x + lc_x;
        end
    end

    // s1: sign/magnitude; both stay within 16 bits after scaling
    logic [16:0] n1_dn;
    logic [16:0] n1_sn;
    logic [15:0] r1_dmag;
    logic [15:0] r1_smag;
    logic        r1_dneg;
    logic        r1_sneg;

    assign n1_dn = ~r0_d + 17'd1;
    assign n1_sn = ~r0_s + 17'd1;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_dmag <= r0_d[16] ? n1_dn[15:0] : r0_d[15:0];
            r1_smag <= r0_s[16] ? n1_sn[15:0] : r0_s[15:0];
            r1_dneg <= r0_d[16];
            r1_sneg <= r0_s[16];
        end
    end

    // s2: times speed_per_cmd
    logic [39:0] r2_pd;
    logic [39:0] r2_ps;
    logic        r2_dneg;
    logic        r2_sneg;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_pd   <= r1_dmag * i_cfg.speed_per_cmd;
            r2_ps   <= r1_smag * i_cfg.speed_per_cmd;
            r2_dneg <= r1_dneg;
            r2_sneg <= r1_sneg;
        end
    end

    // s3: speed = pd / 2^15 saturated; turn partials of ps * inv_track
    logic [15:0] r3_spd;
    logic [43:0] r3_pph;
    logic [43:0] r3_ppl;
    logic        r3_sneg;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_spd  <= ddwc_pkg::sat_signed(r2_dneg, {9'd0, r2_pd[39:15]});
            r3_pph  <= r2_ps[39:20] * i_cfg.inv_track;
            r3_ppl  <= r2_ps[19:0] * i_cfg.inv_track;
            r3_sneg <= r2_sneg;
        end
    end

    // s4: sum partials, Q.40 -> Q.10, saturate
    logic [63:0] n4_full;
    logic [15:0] r4_spd;
    logic [15:0] r4_trn;

    assign n4_full = {r3_pph, 20'd0} + {20'd0, r3_ppl};

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_spd <= r3_spd;
            r4_trn <= ddwc_pkg::sat_signed(r3_sneg, n4_full[63:30]);
        end
    end

    assign o_cmd          = r_c[NS-1];
    assign o_actual_speed = r4_spd;
    assign o_actual_turn  = r4_trn;

endmodule

`default_nettype wire

FILE: hw/rtl/diff_drive_wheel_command_top.sv
`default_nettype none

// Differential drive wheel command. Each input beat carries a linear speed v
// and a yaw rate w (signed Q5.10). The block forms the wheel speeds
// v +/- half_width*w, converts them to signed 16-bit motor commands through
// cmd_per_speed (left command negated, both saturated), and when the larger
// command magnitude exceeds max_cmd scales both by max_cmd / magnitude,
// truncating toward zero so the wheel ratio holds; tuser flags that case.
// It also returns the speed and yaw rate the final commands achieve,
// saturated to 16 bits. One result beat per input beat, in order, no state
// carried between beats. Throughput is one beat per clock while the output
// is not stalled; beats pass through the kinematics/command stages, the
// scaler (one quotient bit per stage plus a select stage) and the back-computation.
// Every stage holds its own valid bit and a stalled stage only stops the
// stages behind it, so input keeps flowing into bubbles while a result
// waits on m_axis_tready. Configuration writes are always taken and must be
// made while no beat is in flight.
module diff_drive_wheel_command_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] lin_speed, [31:16] turn_rate

    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [15:0] left_cmd, [31:16] right_cmd,
                                             // [47:32] actual_speed, [63:48] actual_turn
    output logic             m_axis_tuser,   // [0] was_limited

    // Register write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    // Configuration registers; only the low register-width bits are kept,
    // writes past the last index are dropped
    ddwc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width    <= ddwc_pkg::HALF_WIDTH_RST;
            r_cfg.cmd_per_speed <= ddwc_pkg::CMD_PER_SPEED_RST;
            r_cfg.speed_per_cmd <= ddwc_pkg::SPEED_PER_CMD_RST;
            r_cfg.inv_track     <= ddwc_pkg::INV_TRACK_RST;
            r_cfg.max_cmd       <= ddwc_pkg::MAX_CMD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ddwc_pkg::REG_HALF_WIDTH:    r_cfg.half_width    <= i_cfg_data[15:0];
                ddwc_pkg::REG_CMD_PER_SPEED: r_cfg.cmd_per_speed <= i_cfg_data;
                ddwc_pkg::REG_SPEED_PER_CMD: r_cfg.speed_per_cmd <= i_cfg_data;
                ddwc_pkg::REG_INV_TRACK:     r_cfg.inv_track     <= i_cfg_data;
                ddwc_pkg::REG_MAX_CMD:       r_cfg.max_cmd       <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Kinematics and raw commands
    logic           wh_valid;
    logic           wh_ready;
    ddwc_pkg::t_lim wh_lim;

    ddwc_wheel u_wheel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_lin_speed (s_axis_tdata[15:0]),
        .i_turn_rate (s_axis_tdata[31:16]),
        .i_cfg       (r_cfg),
        .o_valid     (wh_valid),
        .i_ready     (wh_ready),
        .o_lim       (wh_lim)
    );

    // Limit scaling
    logic           dv_valid;
    logic           dv_ready;
    ddwc_pkg::t_cmd dv_cmd;

    ddwc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (wh_valid),
        .o_ready (wh_ready),
        .i_lim   (wh_lim),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_cmd   (dv_cmd)
    );

    // Achieved motion; its last stage is the output register
    ddwc_pkg::t_cmd od_cmd;
    logic [15:0]    od_speed;
    logic [15:0]    od_turn;

    ddwc_odom u_odom (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (dv_valid),
        .o_ready        (dv_ready),
        .i_cmd          (dv_cmd),
        .i_cfg          (r_cfg),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_cmd          (od_cmd),
        .o_actual_speed (od_speed),
        .o_actual_turn  (od_turn)
    );

    assign m_axis_tdata = {od_turn, od_speed,
                           od_cmd.cmd[ddwc_pkg::LANE_R], od_cmd.cmd[ddwc_pkg::LANE_L]};
    assign m_axis_tuser = od_cmd.limited;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
module testbench;

    // Register index past the end of the map; writes there must be dropped.
    localparam ddwc_pkg::t_cfg_idx REG_NONE = 3'd5;

    // Run limit, in time units (clock period is 10).
    localparam longint RUN_LIMIT = 4_000_000;

    // Commanded result of one beat, as seen on m_axis.
    typedef struct {
        logic [15:0] left_cmd;
        logic [15:0] right_cmd;
        logic [15:0] actual_speed;
        logic [15:0] actual_turn;
        logic        was_limited;
    } t_wheel_result;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time at random
        RX_SPARSE,  // ready when the low two bits of the cycle count are zero
        RX_HICCUP   // mostly ready, short random stalls
    } t_rx_mode;

    // Holds the register copy, works out each command's wheel result and
    // checks result beats against them in order.
    class kinematics_check;
        bit [15:0]     half_width;
        bit [23:0]     cmd_per_speed;
        bit [23:0]     speed_per_cmd;
        bit [23:0]     inv_track;
        bit [14:0]     max_cmd;
        t_wheel_result awaited_results[$];
        int            errors;

        function new();
            half_width    = ddwc_pkg::HALF_WIDTH_RST;
            cmd_per_speed = ddwc_pkg::CMD_PER_SPEED_RST;
            speed_per_cmd = ddwc_pkg::SPEED_PER_CMD_RST;
            inv_track     = ddwc_pkg::INV_TRACK_RST;
            max_cmd       = ddwc_pkg::MAX_CMD_RST;
            errors        = 0;
        endfunction

        function void set_reg(ddwc_pkg::t_cfg_idx idx, logic [23:0] data);
            case (idx)
                ddwc_pkg::REG_HALF_WIDTH:    half_width    = data[15:0];
                ddwc_pkg::REG_CMD_PER_SPEED: cmd_per_speed = data;
                ddwc_pkg::REG_SPEED_PER_CMD: speed_per_cmd = data;
                ddwc_pkg::REG_INV_TRACK:     inv_track     = data;
                ddwc_pkg::REG_MAX_CMD:       max_cmd       = data[14:0];
                default: ;
            endcase
        endfunction

        function longint clip16(longint x);
            if (x > 32767) return 32767;
            if (x < -32768) return -32768;
            return x;
        endfunction

        // a * b >> sh, rounding toward zero
        function longint scale_tz(longint a, bit [63:0] b, int unsigned sh);
            bit [63:0] mag;
            bit [63:0] p;
            mag = (a < 0) ? 64'(-a) : 64'(a);
            p = (mag * b) >> sh;
            return (a < 0) ? -longint'(p) : longint'(p);
        endfunction

        function t_wheel_result solve_wheels(logic signed [15:0] v, logic signed [15:0] w);
            t_wheel_result r;
            longint        spin, vr, vl, rc, lc, ml, mr, m, lim, s, spd, trn;
            bit [63:0]     p;
            // wheel speeds in Q.26
            spin = longint'(w) * longint'(half_width);
            vr = longint'(v) * 65536 + spin;
            vl = longint'(v) * 65536 - spin;
            // Q.26 * Q16.8 = Q.34, then clip to 16 bits; left side is negated
            rc = clip16(scale_tz(vr, 64'(cmd_per_speed), 34));
            lc = clip16(-scale_tz(vl, 64'(cmd_per_speed), 34));
            ml = (lc < 0) ? -lc : lc;
            mr = (rc < 0) ? -rc : rc;
            m = (ml > mr) ? ml : mr;
            lim = longint'(max_cmd);
            r.was_limited = 1'b0;
            // proportional limit; a magnitude equal to the limit is left unscaled
            if (m > lim) begin
                lc = lc * lim / m;
                rc = rc * lim / m;
                r.was_limited = 1'b1;
            end
            spd = clip16(scale_tz(rc - lc, 64'(speed_per_cmd), 15));
            s = rc + lc;
            p = 64'((s < 0) ? -s : s) * 64'(speed_per_cmd);
            p = (p * 64'(inv_track)) >> 30;
            if (p > 40000) p = 40000;
            trn = clip16((s < 0) ? -longint'(p) : longint'(p));
            r.left_cmd     = lc[15:0];
            r.right_cmd    = rc[15:0];
            r.actual_speed = spd[15:0];
            r.actual_turn  = trn[15:0];
            return r;
        endfunction

        function void note_command(logic [15:0] v, logic [15:0] w);
            awaited_results.push_back(solve_wheels(v, w));
        endfunction

        function void compare_field(string name, logic [15:0] exp, logic [15:0] got);
            if (got !== exp) begin
                $error("%s: expected %0d (0x%h), got %0d (0x%h)",
                       name, $signed(exp), exp, $signed(got), got);
                errors++;
            end
        endfunction

        function void check_result(logic [63:0] data, logic user);
            t_wheel_result e;
            if (awaited_results.size() == 0) begin
                $error("result beat with no command outstanding: tdata=0x%h tuser=%b",
                       data, user);
                errors++;
                return;
            end
            e = awaited_results.pop_front();
            compare_field("left_cmd", e.left_cmd, data[15:0]);
            compare_field("right_cmd", e.right_cmd, data[31:16]);
            compare_field("actual_speed", e.actual_speed, data[47:32]);
            compare_field("actual_turn", e.actual_turn, data[63:48]);
            compare_field("was_limited", 16'(e.was_limited), 16'(user));
        endfunction

        function void flag_leftovers();
            if (awaited_results.size() != 0) begin
                $error("%0d result beats never arrived", awaited_results.size());
                errors += awaited_results.size();
            end
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [63:0]        m_axis_tdata;
    logic               m_axis_tuser;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    ddwc_pkg::t_cfg_idx i_cfg_index = ddwc_pkg::REG_HALF_WIDTH;
    logic [23:0]        i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    diff_drive_wheel_command_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    kinematics_check book = new();

    int unsigned beats_sent = 0;   // accepted command beats
    int unsigned burst_left = 0;   // beats left in the current sender burst

    // ------------------------------------------------------------------
    // Result side: stall pattern plus one long hold-off
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_mode_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned rx_cycle = 0;

    always @(posedge i_clk) begin
        rx_cycle++;
        // Early in a long phase, block the output long enough for the
        // pipeline to back up and push back on s_axis while beats keep coming.
        if (!hold_done && beats_sent >= 100) begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(50, 300);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= (rx_cycle[1:0] == 2'd0);
                RX_HICCUP: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default:   m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Values seen here are the ones present at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            book.check_result(m_axis_tdata, m_axis_tuser);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one command beat. Bursts of random length with random gaps;
    // tvalid stays high across back-to-back beats.
    task automatic issue_command(input logic [15:0] v, input logic [15:0] w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w, v};
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_command(v, w);
        beats_sent++;
    endtask

    task automatic stop_commands();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // Every command yields a result, so an empty expectation queue means
    // nothing is in flight.
    task automatic wait_drained();
        while (book.outstanding() != 0) @(posedge i_clk);
    endtask

    // One register beat; caller lowers valid after the last one.
    task automatic write_reg(input ddwc_pkg::t_cfg_idx idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.set_reg(idx, data);
    endtask

    // Write the whole map; unused upper bits carry junk that must be dropped.
    task automatic write_settings(input logic [15:0] hw, input logic [23:0] cps,
                                  input logic [23:0] spc, input logic [23:0] inv,
                                  input logic [14:0] mc);
        write_reg(ddwc_pkg::REG_HALF_WIDTH, {8'($urandom), hw});
        write_reg(ddwc_pkg::REG_CMD_PER_SPEED, cps);
        write_reg(ddwc_pkg::REG_SPEED_PER_CMD, spc);
        write_reg(ddwc_pkg::REG_INV_TRACK, inv);
        write_reg(ddwc_pkg::REG_MAX_CMD, {9'($urandom), mc});
        i_cfg_valid <= 1'b0;
    endtask

    // Speed / rate mix: mostly full range, some small, some corner values.
    function automatic logic [15:0] pick_q510();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 10) return 16'($urandom);
        if (r < 16) return 16'($urandom_range(0, 4095) - 2048);
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0001;
            default: return 16'h0000;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] dir_v[13];
        logic [15:0] dir_w[13];
        logic [15:0] hw;
        logic [23:0] cps, spc, inv;
        logic [14:0] mc;
        int unsigned cycles;

        // corners under reset settings
        dir_v = '{16'h0000, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000,
                  16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'd1024, -16'sd3000};
        dir_w = '{16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                  16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'd512, 16'd200};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: saturation on both wheels, negating -32768, and
        // the full-scale reverse case where the magnitude is 32768.
        foreach (dir_v[k]) issue_command(dir_v[k], dir_w[k]);
        stop_commands();
        wait_drained();

        // Tight limit: equal wheel magnitudes over the limit (w = 0),
        // one below it, one mixed turn.
        write_reg(ddwc_pkg::REG_MAX_CMD, {9'h1a5, 15'd1000});
        i_cfg_valid <= 1'b0;
        issue_command(16'd4000, 16'd0);
        issue_command(-16'sd4000, 16'd0);
        issue_command(16'd100, 16'd0);
        issue_command(16'd1024, 16'd300);
        stop_commands();
        wait_drained();

        // Zero limit: anything nonzero collapses to zero and is flagged.
        // The out-of-map index must leave the settings alone.
        write_reg(ddwc_pkg::REG_MAX_CMD, 24'h0);
        write_reg(REG_NONE, 24'h5a5a5a);
        i_cfg_valid <= 1'b0;
        issue_command(16'd0, 16'd0);
        issue_command(16'd500, 16'd0);
        issue_command(16'd0, 16'd300);
        issue_command(16'h8000, 16'h7fff);
        issue_command(16'd2000, 16'd100);
        stop_commands();
        wait_drained();

        // Random phases, each with its own register settings.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    hw = ddwc_pkg::HALF_WIDTH_RST; cps = ddwc_pkg::CMD_PER_SPEED_RST;
                    spc = ddwc_pkg::SPEED_PER_CMD_RST;
                    inv = ddwc_pkg::INV_TRACK_RST; mc = ddwc_pkg::MAX_CMD_RST;
                end
                1: begin
                    hw = '1; cps = '1; spc = '1; inv = '1; mc = '1;
                end
                2: begin
                    hw = '0; cps = '0; spc = '0; inv = '0; mc = '0;
                end
                3: begin
                    hw = '1; cps = ddwc_pkg::CMD_PER_SPEED_RST; spc = '1; inv = '0;
                    mc = 15'($urandom_range(1, 2000));
                end
                default: begin
                    hw  = 16'($urandom);
                    cps = 24'($urandom_range(0, 1 << 21));
                    spc = 24'($urandom_range(0, 1 << 16));
                    inv = 24'($urandom_range(0, 1 << 20));
                    mc  = 15'($urandom_range(0, 32767));
                    if ($urandom_range(0, 9) == 0) cps = '1;
                    if ($urandom_range(0, 9) == 0) spc = '0;
                    if ($urandom_range(0, 9) == 0) mc = '0;
                end
            endcase
            write_settings(hw, cps, spc, inv, mc);
            for (int n = 0; n < 66; n++) begin
                // one mid-phase pause until the pipeline is empty
                if (phase == 4 && n == 33) begin
                    stop_commands();
                    wait_drained();
                end
                issue_command(pick_q510(), pick_q510());
            end
            stop_commands();
            wait_drained();
        end

        // Bounded drain, then a latency's worth of quiet to catch strays.
        cycles = 0;
        while (book.outstanding() != 0 && cycles < 5000) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (40) @(posedge i_clk);
        book.flag_leftovers();
        if (book.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hang guard
    initial begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: diff_drive_wheel_command_top.f
hw/rtl/ddwc_pkg.sv
hw/rtl/ddwc_wheel.sv
hw/rtl/ddwc_div.sv
hw/rtl/ddwc_odom.sv
hw/rtl/diff_drive_wheel_command_top.sv
dv/testbench.sv
